// File: hw/rtl/scd_pkg.sv
// Shared types, constants and helpers for the stereo chorus delay.
// No dependencies; every other source file imports this package.
package scd_pkg;

  // Ring depth is a power of two; positions wrap by masking.
  localparam int RING_DEPTH   = 4096;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int SAMPLE_BITS  = 24;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_AW      = $clog2(SINE_ENTRIES);

  // Read position: integer sample index plus 16 fraction bits
  localparam int POS_W  = RING_AW + 16;
  // Cubic coefficient and accumulator widths
  localparam int COEF_W = SAMPLE_BITS + 3;
  localparam int ACC_W  = SAMPLE_BITS + 22;
  // Width of values handed to the saturator
  localparam int SAT_W  = SAMPLE_BITS + 8;

  localparam longint SMAX_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam longint SMIN_L = -SMAX_L - 64'sd1;

  // Configuration register indexes
  localparam logic [2:0] CFG_BASE_DELAY    = 3'd0;
  localparam logic [2:0] CFG_DEPTH_GAIN    = 3'd1;
  localparam logic [2:0] CFG_PHASE_STEP    = 3'd2;
  localparam logic [2:0] CFG_RIGHT_OFFSET  = 3'd3;
  localparam logic [2:0] CFG_FEEDBACK_GAIN = 3'd4;
  localparam logic [2:0] CFG_WET_MIX       = 3'd5;

  localparam logic [16:0] WET_FULL = 17'h10000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WR, ST_M1, ST_M2, ST_M3,
    ST_RD0, ST_RD1, ST_RD2, ST_RD3,
    ST_I1, ST_I2, ST_I3, ST_I4, ST_I5,
    ST_FB, ST_MIX, ST_OUT
  } scd_state_t;

  typedef struct packed {
    logic [10:0] base_delay;
    logic [15:0] depth_gain;
    logic [15:0] feedback_gain;
    logic [16:0] wet_mix;
  } scd_cfg_t;

  // Ring fill status: entries below or at wp are written, all once wrapped
  typedef struct packed {
    logic [RING_AW-1:0] wp;
    logic               wrapped;
  } scd_fill_t;

  typedef struct packed {
    scd_state_t state;
    logic       accept;
    scd_fill_t  fill;
  } scd_ctl_t;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  // Polynomial sine, Q1.15, one entry per table slot
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint p, q, f, u, u2, t, s;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      p  = (longint'(i) <<< 18) / SINE_ENTRIES;
      q  = (p >>> 16) & 3;
      f  = p & 65535;
      u  = (q % 2 == 1) ? 65536 - f : f;
      u2 = (u * u) >>> 16;
      t  = 102944 - (((42334 - ((4926 * u2) >>> 16)) * u2) >>> 16);
      s  = ((t * u) >>> 16) >>> 1;
      if (s > 32767) s = 32767;
      tab[i] = (q >= 2) ? 16'(-s) : 16'(s);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine();

  // Clamp to the signed sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_W-1:0] v);
    if (v > $signed(SAT_W'(SMAX_L))) return SAMPLE_BITS'(SMAX_L);
    if (v < $signed(SAT_W'(SMIN_L))) return SAMPLE_BITS'(SMIN_L);
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

// File: hw/rtl/scd_ring.sv
// Delay ring for one channel: synchronous memory, one write and one read port.
// Unwritten entries read as zero through the fill status. Depends on scd_pkg.
module scd_ring (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [scd_pkg::RING_AW-1:0]         wr_addr,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic [scd_pkg::RING_AW-1:0]         rd_addr,
  input  scd_pkg::scd_fill_t                  fill,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] rd_data
);
  import scd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic                          rd_valid_r;

  // Write the new sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Track whether the entry read has been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= fill.wrapped || (rd_addr <= fill.wp);
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// File: hw/rtl/scd_chan.sv
// One channel of the chorus: ring write, LFO delay, four tap reads,
// cubic interpolation, feedback and dry/wet mix. Depends on scd_pkg, scd_ring.
module scd_chan (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  scd_pkg::scd_ctl_t                      ctl,
  input  scd_pkg::scd_cfg_t                      cfg,
  input  logic [31:0]                            phase,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] din,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] dout
);
  import scd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] din_r, fb_r, wet_r, mix_r;
  logic signed [SAMPLE_BITS-1:0] y0_r, y1_r, y2_r;
  logic signed [SAMPLE_BITS-1:0] ring_wdata, ring_rdata;
  logic [RING_AW-1:0]            rd_addr, x_r;
  logic [15:0]                   f_r, f2_r, f3_r;
  logic signed [32:0]            p1_r;
  logic signed [33:0]            p2_r;
  logic signed [29:0]            p3_r;
  logic signed [COEF_W-1:0]      a0_r, a1_r, a2_r, a0_c, a1_c;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [SAMPLE_BITS+18:0] dry_r, mix_sum;
  logic signed [39:0]            pos_ext;
  logic signed [16:0]            depth_s, fbg_s;
  logic signed [17:0]            w_s, dry_coef;
  logic signed [11:0]            base_s;
  logic [16:0]                   w_clip;
  logic signed [SAMPLE_BITS+16:0] fb_prod;

  assign depth_s  = $signed({1'b0, cfg.depth_gain});
  assign fbg_s    = $signed({1'b0, cfg.feedback_gain});
  assign base_s   = $signed({1'b0, cfg.base_delay});
  assign w_clip   = (cfg.wet_mix > WET_FULL) ? WET_FULL : cfg.wet_mix;
  assign w_s      = $signed({1'b0, w_clip});
  assign dry_coef = $signed({1'b0, WET_FULL}) - w_s;

  // Ring input: sample plus feedback, saturated
  assign ring_wdata = sat_sample(SAT_W'(din_r) + SAT_W'(fb_r));

  // Read position: write pointer minus modulated delay, wrapped to the ring
  assign pos_ext = $signed({8'b0, ctl.fill.wp, 16'b0})
                 - $signed({13'b0, cfg.base_delay, 16'b0})
                 - (40'(p3_r) <<< 1);

  // Tap addresses around the read point
  always_comb begin
    unique case (ctl.state)
      ST_RD0:  rd_addr = x_r - RING_AW'(1);
      ST_RD2:  rd_addr = x_r + RING_AW'(1);
      ST_RD3:  rd_addr = x_r + RING_AW'(2);
      default: rd_addr = x_r;
    endcase
  end

  // Cubic coefficients from the four taps (fourth arrives from the ring)
  assign a0_c = COEF_W'(ring_rdata) - COEF_W'(y2_r) - COEF_W'(y0_r) + COEF_W'(y1_r);
  assign a1_c = COEF_W'(y0_r) - COEF_W'(y1_r) - a0_c;

  assign fb_prod = wet_r * fbg_s;
  assign mix_sum = dry_r + (SAMPLE_BITS+19)'(wet_r * w_s);

  scd_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ctl.state == ST_WR),
    .wr_addr (ctl.fill.wp),
    .wr_data (ring_wdata),
    .rd_addr (rd_addr),
    .fill    (ctl.fill),
    .rd_data (ring_rdata)
  );

  // Step the datapath through the sequence
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      din_r <= din;
    end
    unique case (ctl.state)
      ST_WR: begin
        p1_r <= SINE_TABLE[phase[31 -: SINE_AW]] * depth_s;
      end
      ST_M1: begin
        p2_r <= $signed(p1_r[32:16]) * depth_s;
      end
      ST_M2: begin
        p3_r <= base_s * $signed(p2_r[33:16]);
      end
      ST_M3: begin
        x_r <= pos_ext[POS_W-1:16];
        f_r <= pos_ext[15:0];
      end
      ST_RD0: begin
        f2_r <= 16'((32'(f_r) * 32'(f_r)) >> 16);
      end
      ST_RD1: begin
        y0_r <= ring_rdata;
        f3_r <= 16'((32'(f2_r) * 32'(f_r)) >> 16);
      end
      ST_RD2: begin
        y1_r <= ring_rdata;
      end
      ST_RD3: begin
        y2_r <= ring_rdata;
      end
      ST_I1: begin
        a0_r <= a0_c;
        a1_r <= a1_c;
        a2_r <= COEF_W'(y2_r) - COEF_W'(y0_r);
      end
      ST_I2: begin
        acc_r <= a0_r * $signed({1'b0, f3_r});
      end
      ST_I3: begin
        acc_r <= acc_r + ACC_W'(a1_r * $signed({1'b0, f2_r}));
      end
      ST_I4: begin
        acc_r <= acc_r + ACC_W'(a2_r * $signed({1'b0, f_r}));
      end
      ST_I5: begin
        wet_r <= sat_sample(SAT_W'($signed(acc_r[ACC_W-1:16])) + SAT_W'(y1_r));
      end
      ST_FB: begin
        dry_r <= din_r * dry_coef;
      end
      ST_MIX: begin
        mix_r <= sat_sample(SAT_W'($signed(mix_sum[SAMPLE_BITS+18:16])));
      end
      default: begin
      end
    endcase
  end

  // Hold feedback state; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else if (ctl.state == ST_FB) begin
      fb_r <= fb_prod[SAMPLE_BITS+15:16];
    end
  end

  assign dout = mix_r;

endmodule

// File: hw/rtl/stereo_chorus_delay.sv
// Top level of the stereo chorus delay: sequencer, LFO phase, write pointer,
// configuration registers and output register. Depends on scd_pkg, scd_chan.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    in_left_in, in_right_in
//   out      source     out_valid/out_stall  out_left_out, out_right_out
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request passes through WR, M1 to M3, RD0 to RD3, I1 to I5, FB, MIX and OUT;
// no new request is taken until the sequencer is back in IDLE. The
// sequence is set by the four one-at-a-time tap reads of each ring and the
// chained multiplies of the LFO and interpolation steps.
// Reset is synchronous; rings need no clearing pass, unwritten entries read 0.
// A stalled result holds in the output register; the sequencer waits for it.
module stereo_chorus_delay (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_right_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_left_out,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_right_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [2:0]                             cfg_index,
  input  logic [31:0]                            cfg_data
);
  import scd_pkg::*;

  scd_state_t                    state_r, state_nxt;
  logic [RING_AW-1:0]            wp_r;
  logic                          wrapped_r;
  logic [31:0]                   phase_r, right_phase;
  logic [23:0]                   phase_step_r;
  logic [31:0]                   right_offset_r;
  scd_cfg_t                      cfg_r;
  scd_ctl_t                      ctl;
  logic                          accept, load, out_valid_r;
  logic signed [SAMPLE_BITS-1:0] left_mix, right_mix, left_out_r, right_out_r;

  assign accept      = in_valid && !in_stall;
  assign right_phase = phase_r + right_offset_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_I1;
      ST_I1:   state_nxt = ST_I2;
      ST_I2:   state_nxt = ST_I3;
      ST_I3:   state_nxt = ST_I4;
      ST_I4:   state_nxt = ST_I5;
      ST_I5:   state_nxt = ST_FB;
      ST_FB:   state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = 1'b1;
    load      = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance write pointer and LFO phase once per finished request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      phase_r   <= '0;
    end else if (load) begin
      wp_r    <= wp_r + RING_AW'(1);
      phase_r <= phase_r + {8'b0, phase_step_r};
      if (wp_r == RING_AW'(RING_DEPTH - 1)) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_delay    <= 11'd480;
      cfg_r.depth_gain    <= 16'd32768;
      phase_step_r        <= 24'd179;
      right_offset_r      <= '0;
      cfg_r.feedback_gain <= '0;
      cfg_r.wet_mix       <= 17'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_DELAY:    cfg_r.base_delay    <= cfg_data[10:0];
        CFG_DEPTH_GAIN:    cfg_r.depth_gain    <= cfg_data[15:0];
        CFG_PHASE_STEP:    phase_step_r        <= cfg_data[23:0];
        CFG_RIGHT_OFFSET:  right_offset_r      <= cfg_data;
        CFG_FEEDBACK_GAIN: cfg_r.feedback_gain <= cfg_data[15:0];
        CFG_WET_MIX:       cfg_r.wet_mix       <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  assign ctl.state        = state_r;
  assign ctl.accept       = accept;
  assign ctl.fill.wp      = wp_r;
  assign ctl.fill.wrapped = wrapped_r;

  scd_chan u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cfg   (cfg_r),
    .phase (phase_r),
    .din   (in_left_in),
    .dout  (left_mix)
  );

  scd_chan u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cfg   (cfg_r),
    .phase (right_phase),
    .din   (in_right_in),
    .dout  (right_mix)
  );

  // Output register: load a finished pair, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_out_r  <= left_mix;
      right_out_r <= right_mix;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = left_out_r;
  assign out_right_out = right_out_r;

endmodule

// File: hw/rtl/scd_checker.sv
// Port-level checks for the stereo chorus delay, bound to the top level.
// Depends on scd_pkg for the sample width.
module scd_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic signed [scd_pkg::SAMPLE_BITS-1:0] in_left_in,
  input logic signed [scd_pkg::SAMPLE_BITS-1:0] in_right_in,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [scd_pkg::SAMPLE_BITS-1:0] out_left_out,
  input logic signed [scd_pkg::SAMPLE_BITS-1:0] out_right_out,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready,
  input logic [2:0]                             cfg_index,
  input logic [31:0]                            cfg_data
);
  import scd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled result changed");

  // One request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // Leave reset empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind stereo_chorus_delay scd_checker u_scd_checker (.*);

// File: tb/tb_top.sv
// Self-checking bench for the stereo chorus delay: drives sample pairs and
// register writes, predicts each mixed output pair. Depends on scd_pkg and stereo_chorus_delay.
module tb_top;
  import scd_pkg::*;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } pair_t;

  localparam int CYCLE_LIMIT = 900000;
  localparam int SETTLE      = 40;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic signed [23:0] in_left_in, in_right_in;
  logic out_valid, out_stall;
  logic signed [23:0] out_left_out, out_right_out;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  stereo_chorus_delay dut (.*);

  // Pending sample pairs and expected output pairs
  pair_t pending_q[$];
  pair_t mix_expect_q[$];
  int    errors = 0;
  bit    quiet = 0;
  int    rx_hold = 0;
  int    tx_gap = 0;
  int    rx_gap = 0;
  int    cycles = 0;

  // Shadow of block state and registers
  logic signed [23:0] ring_l [4096];
  logic signed [23:0] ring_r [4096];
  logic [11:0]        wptr;
  logic [31:0]        lfo_ph;
  longint             fb_l, fb_r;
  logic [10:0]        base_r;
  logic [15:0]        depth_r;
  logic [23:0]        step_r;
  logic [31:0]        offs_r;
  logic [15:0]        fbgain_r;
  logic [16:0]        wet_r;
  longint             sine_lut [256];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Polynomial sine, Q1.15, quarter-cycle folding
  initial begin
    longint p, q, f, u, u2, t, s;
    for (int i = 0; i < 256; i++) begin
      p  = (longint'(i) << 18) / 256;
      q  = (p >> 16) & 3;
      f  = p & 65535;
      u  = q[0] ? 65536 - f : f;
      u2 = (u * u) >> 16;
      t  = 102944 - (((42334 - ((4926 * u2) >> 16)) * u2) >> 16);
      s  = ((t * u) >> 16) >> 1;
      if (s > 32767) s = 32767;
      sine_lut[i] = (q >= 2) ? -s : s;
    end
  end

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Cubic-interpolated read of one ring at the modulated delay
  function automatic longint chorus_tap(input bit right, input logic [31:0] ph);
    longint m, dly, pos, f, f2, f3, y0, y1, y2, y3, a0, a1, a2;
    int x;
    m   = (sine_lut[ph[31:24]] * longint'(depth_r)) >>> 16;
    m   = (m * longint'(depth_r)) >>> 16;
    dly = (longint'(base_r) << 16) + longint'(base_r) * m * 2;
    pos = ((longint'(wptr) << 16) - dly) & 64'h0FFF_FFFF;
    x   = int'(pos >> 16);
    f   = pos & 65535;
    y0  = right ? ring_r[(x + 4095) % 4096] : ring_l[(x + 4095) % 4096];
    y1  = right ? ring_r[x] : ring_l[x];
    y2  = right ? ring_r[(x + 1) % 4096] : ring_l[(x + 1) % 4096];
    y3  = right ? ring_r[(x + 2) % 4096] : ring_l[(x + 2) % 4096];
    a0  = y3 - y2 - y0 + y1;
    a1  = y0 - y1 - a0;
    a2  = y2 - y0;
    f2  = (f * f) >> 16;
    f3  = (f2 * f) >> 16;
    return clamp24(((a0 * f3 + a1 * f2 + a2 * f) >>> 16) + y1);
  endfunction

  function automatic longint blend(input longint dry, input longint wet);
    longint w;
    w = (wet_r > 17'h10000) ? 65536 : longint'(wet_r);
    return clamp24((dry * (65536 - w) + wet * w) >>> 16);
  endfunction

  // Advance the shadow state by one sample pair and queue the expected output
  function automatic void predict_chorus(input pair_t s);
    longint wl, wr;
    pair_t r;
    ring_l[wptr] = 24'(clamp24(longint'(s.left) + fb_l));
    ring_r[wptr] = 24'(clamp24(longint'(s.right) + fb_r));
    wl = chorus_tap(0, lfo_ph);
    wr = chorus_tap(1, lfo_ph + offs_r);
    fb_l = (wl * longint'(fbgain_r)) >>> 16;
    fb_r = (wr * longint'(fbgain_r)) >>> 16;
    r.left  = 24'(blend(longint'(s.left), wl));
    r.right = 24'(blend(longint'(s.right), wr));
    mix_expect_q = {mix_expect_q, r};
    wptr   = wptr + 12'd1;
    lfo_ph = lfo_ph + {8'd0, step_r};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Driver: present pending pairs, hold while stalled, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_chorus(pending_q.pop_front());
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        tx_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_valid    <= 1'b1;
        in_left_in  <= pending_q[0].left;
        in_right_in <= pending_q[0].right;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Count down the long receiver hold
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
    end
  end

  // Monitor: compare accepted outputs, stall in bursts or long holds
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (mix_expect_q.size() == 0) begin
        report_mismatch("unexpected pair", out_left_out, 0);
      end else begin
        want = mix_expect_q.pop_front();
        if (out_left_out !== want.left)
          report_mismatch("left_out", out_left_out, want.left);
        if (out_right_out !== want.right)
          report_mismatch("right_out", out_right_out, want.right);
      end
    end
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      rx_gap = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Register write; shadow copy updates at the handshake edge
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_DELAY:    base_r   = val[10:0];
      CFG_DEPTH_GAIN:    depth_r  = val[15:0];
      CFG_PHASE_STEP:    step_r   = val[23:0];
      CFG_RIGHT_OFFSET:  offs_r   = val;
      CFG_FEEDBACK_GAIN: fbgain_r = val[15:0];
      CFG_WET_MIX:       wet_r    = val[16:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] b, input logic [31:0] d, input logic [31:0] s,
                           input logic [31:0] o, input logic [31:0] g, input logic [31:0] w);
    write_reg(CFG_BASE_DELAY, b);
    write_reg(CFG_DEPTH_GAIN, d);
    write_reg(CFG_PHASE_STEP, s);
    write_reg(CFG_RIGHT_OFFSET, o);
    write_reg(CFG_FEEDBACK_GAIN, g);
    write_reg(CFG_WET_MIX, w);
  endtask

  // Wait for every expected pair, then let the sequencer settle
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || mix_expect_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 511)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic push_random(input int n);
    pair_t s;
    repeat (n) begin
      s.left  = rand_sample();
      s.right = rand_sample();
      pending_q = {pending_q, s};
    end
  endtask

  task automatic push_pair(input logic signed [23:0] l, input logic signed [23:0] r);
    pair_t s;
    s.left  = l;
    s.right = r;
    pending_q = {pending_q, s};
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_left_in  <= '0;
    in_right_in <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    foreach (ring_l[i]) begin
      ring_l[i] = '0;
      ring_r[i] = '0;
    end
    wptr = '0; lfo_ph = '0; fb_l = 0; fb_r = 0;
    base_r = 11'd480; depth_r = 16'd32768; step_r = 24'd179;
    offs_r = '0; fbgain_r = '0; wet_r = 17'd32768;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: extremes and signs
    push_pair(24'sh7FFFFF, 24'sh800000);
    push_pair(24'sh800000, 24'sh7FFFFF);
    push_pair(24'sd0, 24'sd0);
    push_pair(24'sh7FFFFF, 24'sh7FFFFF);
    push_pair(-24'sd1, 24'sd1);
    drain();

    // Zero delay with strong feedback: reads just-written sample, ring saturates
    write_all(32'd0, 32'd65535, 32'hFFFFFF, 32'h8000_0000, 32'd64225, 32'd65536);
    repeat (6) push_pair(24'sh7FFFFF, 24'sh800000);
    repeat (4) push_pair(24'sh800000, 24'sh7FFFFF);
    drain();

    // Base delay 2046, excess feedback and wet bits masked off
    write_all(32'hFFFF_F7FE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (5) push_pair(24'sh7FFFFF, 24'sh7FFFFF);
    push_random(5);
    drain();

    // Receiver holds off while the sender keeps offering
    write_all(32'd1, 32'd40000, 32'd179, 32'h4000_0000, 32'd30000, 32'd0);
    rx_hold = 600;
    push_random(60);
    drain();

    // Random settings per phase
    for (int ph = 0; ph < 8; ph++) begin
      write_all($urandom_range(0, 2047), $urandom, $urandom_range(0, 24'hFFFFFF),
                $urandom, $urandom_range(0, 65535), $urandom_range(0, 17'h1FFFF));
      push_random(230);
      drain();
    end

    // Quiet tail
    quiet = 1;
    write_all(32'd2046, 32'd65535, 32'd1000, 32'd0, 32'd64225, 32'd65536);
    push_random(150);
    drain();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/scd_pkg.sv
hw/rtl/scd_ring.sv
hw/rtl/scd_chan.sv
hw/rtl/stereo_chorus_delay.sv
hw/rtl/scd_checker.sv
tb/tb_top.sv
